// ===== rtl/core/r2b_pkg.sv =====
// Shared types, widths, defaults and register indexes for the raster-to-block converter.
package r2b_pkg;

    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int BCOL_W      = 8;
    localparam int BROW_W      = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_BLOCK_SIZE = 8;
    localparam int DEF_MAX_WIDTH  = 2048;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic [BCOL_W-1:0] block_col;
        logic [BROW_W-1:0] block_row;
        logic              last_of_block;
    } blk_out_t;

endpackage

// ===== rtl/core/r2b_strip_ram.sv =====
// Strip buffer: single write port, single read port with registered read data.
module r2b_strip_ram
    import r2b_pkg::*;
#(
    parameter int DEPTH = DEF_BLOCK_SIZE * DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem_reg [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // Store incoming pixel
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/raster_to_block_converter_core.sv =====
// Raster-to-block converter top level: strip buffer control, block readout and output register.
//
//  port group | dir | handshake        | payload
//  cfg_wr_*   | in  | cfg_wr_en        | cfg_wr_index, cfg_wr_data
//  s_*        | in  | s_valid/s_ready  | s_data (pix_in_t): red, green, blue
//  m_*        | out | m_valid/m_ready  | m_data (blk_out_t): pixel, block_col/row, last
//
// A pixel is taken and written to the strip buffer. A pixel that completes a block starts a
// readout of BLOCK_SIZE*BLOCK_SIZE requests, one per cycle unless the read stage is held,
// from the single strip buffer read port; s_ready stays low until the last read is issued.
// Each request passes through the read stage and the output register to m_data. Reset
// clears counters and flags and loads 640 x 480; the strip buffer is not cleared. Low
// m_ready while m_valid is high freezes the read stage and the output register.
module raster_to_block_converter_core
    import r2b_pkg::*;
#(
    parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output blk_out_t              m_data
);

    localparam int DEPTH = BLOCK_SIZE * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(BLOCK_SIZE);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > WIDTH_W) ? WW : WIDTH_W;

    localparam logic [SW-1:0] SUB_LAST = SW'(BLOCK_SIZE - 1);

    // Configuration registers
    logic [WIDTH_W-1:0]  cfg_width_reg;
    logic [HEIGHT_W-1:0] cfg_height_reg;

    // Raster position counters
    logic [CW-1:0]       col_reg, col_next;
    logic [SW-1:0]       csub_reg, csub_next;
    logic [BCOL_W-1:0]   bcol_reg, bcol_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [SW-1:0]       srow_reg, srow_next;
    logic [BROW_W-1:0]   brow_reg, brow_next;

    // Readout sequencer
    logic                emitting_reg, emitting_next;
    logic [SW-1:0]       ex_reg, ex_next;
    logic [SW-1:0]       ey_reg, ey_next;
    logic [CW-1:0]       em_base_reg, em_base_next;
    logic [SW-1:0]       em_limx_reg, em_limx_next;
    logic [SW-1:0]       em_limy_reg, em_limy_next;
    logic [BCOL_W-1:0]   em_bc_reg, em_bc_next;
    logic [BROW_W-1:0]   em_br_reg, em_br_next;

    // Read stage and output register
    logic                s1_vld_reg, s1_vld_next;
    logic                s1_pad_reg;
    logic                s1_last_reg;
    logic [BCOL_W-1:0]   s1_bc_reg;
    logic [BROW_W-1:0]   s1_br_reg;
    logic                m_valid_reg, m_valid_next;
    blk_out_t            m_data_reg;

    // Combinational helpers
    logic [EW-1:0]       width_ext;
    logic [CW-1:0]       last_col;
    logic [HEIGHT_W-1:0] last_row;
    logic                col_wrap, row_wrap;
    logic [CW-1:0]       col_cur;
    logic [SW-1:0]       csub_cur, srow_cur;
    logic [BCOL_W-1:0]   bcol_cur;
    logic [HEIGHT_W-1:0] row_cur;
    logic [BROW_W-1:0]   brow_cur;
    logic                at_col_last, at_row_last, csub_last, srow_last;
    logic                blk_done;
    logic                pix_acc, cfg_hit;
    logic                advance, rd_issue, rd_pad, rd_last;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [PIX_W-1:0]    rd_data;

    // Effective last column and last row
    assign width_ext = EW'(cfg_width_reg);
    assign last_col  = (width_ext == '0) ? '0 :
                       (width_ext > EW'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                       CW'(width_ext - EW'(1));
    assign last_row  = (cfg_height_reg == '0) ? '0 : cfg_height_reg - HEIGHT_W'(1);

    // Fold a position outside the image back to the origin
    assign col_wrap = (col_reg > last_col);
    assign row_wrap = (row_reg > last_row);
    assign col_cur  = col_wrap ? '0 : col_reg;
    assign csub_cur = col_wrap ? '0 : csub_reg;
    assign bcol_cur = col_wrap ? '0 : bcol_reg;
    assign row_cur  = row_wrap ? '0 : row_reg;
    assign srow_cur = row_wrap ? '0 : srow_reg;
    assign brow_cur = row_wrap ? '0 : brow_reg;

    assign at_col_last = (col_cur == last_col);
    assign at_row_last = (row_cur == last_row);
    assign csub_last   = (csub_cur == SUB_LAST);
    assign srow_last   = (srow_cur == SUB_LAST);
    assign blk_done    = (csub_last || at_col_last) && (srow_last || at_row_last);

    assign s_ready = !emitting_reg;
    assign pix_acc = s_valid && s_ready;
    assign cfg_hit = cfg_wr_en &&
                     (cfg_wr_index == REG_IMAGE_WIDTH || cfg_wr_index == REG_IMAGE_HEIGHT);

    // Pipeline flow: output register frees, read stage moves, sequencer issues
    assign advance  = !m_valid_reg || m_ready;
    assign rd_issue = emitting_reg && (!s1_vld_reg || advance);
    assign rd_pad   = (ex_reg > em_limx_reg) || (ey_reg > em_limy_reg);
    assign rd_last  = (ex_reg == SUB_LAST) && (ey_reg == SUB_LAST);

    // Strip buffer addresses: row slot times buffer width plus column
    assign wr_addr = AW'(srow_cur) * AW'(MAX_WIDTH) + AW'(col_cur);
    assign rd_addr = AW'(ey_reg) * AW'(MAX_WIDTH) + AW'(em_base_reg) + AW'(ex_reg);

    r2b_strip_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_strip_ram (
        .aclk    (aclk),
        .wr_en   (pix_acc),
        .wr_addr (wr_addr),
        .wr_data ({s_data.red, s_data.green, s_data.blue}),
        .rd_en   (rd_issue && !rd_pad),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance raster counters; restart the frame on a width or height register write
    always_comb begin
        col_next  = col_reg;
        csub_next = csub_reg;
        bcol_next = bcol_reg;
        row_next  = row_reg;
        srow_next = srow_reg;
        brow_next = brow_reg;
        if (cfg_hit) begin
            col_next  = '0;
            csub_next = '0;
            bcol_next = '0;
            row_next  = '0;
            srow_next = '0;
            brow_next = '0;
        end else if (pix_acc) begin
            if (at_col_last) begin
                col_next  = '0;
                csub_next = '0;
                bcol_next = '0;
                if (at_row_last) begin
                    row_next  = '0;
                    srow_next = '0;
                    brow_next = '0;
                end else begin
                    row_next  = row_cur + HEIGHT_W'(1);
                    srow_next = srow_last ? '0 : srow_cur + SW'(1);
                    brow_next = srow_last ? brow_cur + BROW_W'(1) : brow_cur;
                end
            end else begin
                col_next  = col_cur + CW'(1);
                csub_next = csub_last ? '0 : csub_cur + SW'(1);
                bcol_next = csub_last ? bcol_cur + BCOL_W'(1) : bcol_cur;
                row_next  = row_cur;
                srow_next = srow_cur;
                brow_next = brow_cur;
            end
        end
    end

    // Start a readout on block completion, then step x and y per read request
    always_comb begin
        emitting_next = emitting_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        em_base_next  = em_base_reg;
        em_limx_next  = em_limx_reg;
        em_limy_next  = em_limy_reg;
        em_bc_next    = em_bc_reg;
        em_br_next    = em_br_reg;
        if (pix_acc && blk_done) begin
            emitting_next = 1'b1;
            ex_next       = '0;
            ey_next       = '0;
            em_base_next  = col_cur - CW'(csub_cur);
            em_limx_next  = csub_cur;
            em_limy_next  = srow_cur;
            em_bc_next    = bcol_cur;
            em_br_next    = brow_cur;
        end else if (rd_issue) begin
            if (rd_last) begin
                emitting_next = 1'b0;
            end
            if (ex_reg == SUB_LAST) begin
                ex_next = '0;
                ey_next = (ey_reg == SUB_LAST) ? '0 : ey_reg + SW'(1);
            end else begin
                ex_next = ex_reg + SW'(1);
            end
        end
    end

    // Read stage and output register valid flags
    always_comb begin
        s1_vld_next  = s1_vld_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = s1_vld_reg;
            s1_vld_next  = 1'b0;
        end
        if (rd_issue) begin
            s1_vld_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= RST_IMAGE_WIDTH;
            cfg_height_reg <= RST_IMAGE_HEIGHT;
            col_reg        <= '0;
            csub_reg       <= '0;
            bcol_reg       <= '0;
            row_reg        <= '0;
            srow_reg       <= '0;
            brow_reg       <= '0;
            emitting_reg   <= 1'b0;
            ex_reg         <= '0;
            ey_reg         <= '0;
            s1_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_wr_index == REG_IMAGE_WIDTH) begin
                cfg_width_reg <= cfg_wr_data[WIDTH_W-1:0];
            end
            if (cfg_wr_en && cfg_wr_index == REG_IMAGE_HEIGHT) begin
                cfg_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
            end
            col_reg      <= col_next;
            csub_reg     <= csub_next;
            bcol_reg     <= bcol_next;
            row_reg      <= row_next;
            srow_reg     <= srow_next;
            brow_reg     <= brow_next;
            emitting_reg <= emitting_next;
            ex_reg       <= ex_next;
            ey_reg       <= ey_next;
            s1_vld_reg   <= s1_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Readout parameters latched at block completion
    always_ff @(posedge aclk) begin
        em_base_reg <= em_base_next;
        em_limx_reg <= em_limx_next;
        em_limy_reg <= em_limy_next;
        em_bc_reg   <= em_bc_next;
        em_br_reg   <= em_br_next;
    end

    // Tag the read request while its data is fetched
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            s1_pad_reg  <= rd_pad;
            s1_last_reg <= rd_last;
            s1_bc_reg   <= em_bc_reg;
            s1_br_reg   <= em_br_reg;
        end
    end

    // Load the output register; drop pixel data for padded positions
    always_ff @(posedge aclk) begin
        if (advance && s1_vld_reg) begin
            m_data_reg.out_red       <= s1_pad_reg ? '0 : rd_data[23:16];
            m_data_reg.out_green     <= s1_pad_reg ? '0 : rd_data[15:8];
            m_data_reg.out_blue      <= s1_pad_reg ? '0 : rd_data[7:0];
            m_data_reg.block_col     <= s1_bc_reg;
            m_data_reg.block_row     <= s1_br_reg;
            m_data_reg.last_of_block <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Never issue a read request into a read stage that is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !advance) |-> !rd_issue)
        else $error("read request issued into a held read stage");

    // A completing pixel starts the readout at the block's first position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_acc && blk_done && !cfg_hit) |=> (emitting_reg && ex_reg == '0 && ey_reg == '0))
        else $error("block completion did not start readout");

    // Sub-block counters stay inside the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        (csub_reg <= SUB_LAST) && (srow_reg <= SUB_LAST) &&
        (ex_reg <= SUB_LAST) && (ey_reg <= SUB_LAST))
        else $error("sub-block counter out of range");

endmodule
